// ===== hw/rtl/skf_pkg.sv =====
// Shared types and constants for the scalar range filter.
// Holds field widths, register reset values, register indexes and the
// command and status words between the controller and the datapath.
package skf_pkg;

	localparam int FRAC_BITS_DEF = 8;
	localparam int GAIN_BITS_DEF = 16;

	localparam int SAMPLE_W    = 15;
	localparam int EST_INT_W   = 15;
	localparam int ERR_INT_W   = 24;
	localparam int Q_W         = 16;
	localparam int R_W         = 16;
	localparam int INIT_ERR_W  = 20;
	localparam int INIT_EST_W  = 15;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 20;

	localparam int RST_PROCESS_NOISE    = 10;
	localparam int RST_SENSOR_NOISE     = 200;
	localparam int RST_INITIAL_ERROR    = 5000;
	localparam int RST_INITIAL_ESTIMATE = 4000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROCESS_NOISE    = 4'd0,
		REG_SENSOR_NOISE     = 4'd1,
		REG_INITIAL_ERROR    = 4'd2,
		REG_INITIAL_ESTIMATE = 4'd3
	} skf_reg_idx_t;

	typedef struct packed {
		logic [Q_W-1:0]        q;
		logic [R_W-1:0]        r;
		logic [INIT_ERR_W-1:0] init_err;
		logic [INIT_EST_W-1:0] init_est;
	} skf_cfg_t;

	typedef struct packed {
		logic capture;
		logic prep;
		logic setup;
		logic div_step;
		logic ksel;
		logic var_step;
		logic finish;
	} skf_cmd_t;

	typedef struct packed {
		logic out_free;
	} skf_status_t;

endpackage

// ===== hw/rtl/skf_regs.sv =====
// Configuration register file for the scalar range filter.
// Depends on skf_pkg for register indexes, widths and reset values.
module skf_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [skf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [skf_pkg::CFG_DATA_W-1:0] cfg_data,
	output skf_pkg::skf_cfg_t             cfg
);
	import skf_pkg::*;

	skf_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.q        <= Q_W'(RST_PROCESS_NOISE);
			cfg_q.r        <= R_W'(RST_SENSOR_NOISE);
			cfg_q.init_err <= INIT_ERR_W'(RST_INITIAL_ERROR);
			cfg_q.init_est <= INIT_EST_W'(RST_INITIAL_ESTIMATE);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PROCESS_NOISE:    cfg_q.q        <= cfg_data[Q_W-1:0];
				REG_SENSOR_NOISE:     cfg_q.r        <= cfg_data[R_W-1:0];
				REG_INITIAL_ERROR:    cfg_q.init_err <= cfg_data[INIT_ERR_W-1:0];
				REG_INITIAL_ESTIMATE: cfg_q.init_est <= cfg_data[INIT_EST_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/skf_ctrl.sv =====
// Sequencer for the scalar range filter: steps one word through
// predict, gain division, gain select, variance multiply and writeback.
// Depends on skf_pkg for the command and status words.
module skf_ctrl #(
	parameter int GAIN_BITS = skf_pkg::GAIN_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  skf_pkg::skf_status_t status,
	output skf_pkg::skf_cmd_t    cmd
);
	import skf_pkg::*;

	localparam int CNT_W = $clog2(GAIN_BITS + 2);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_PREP  = 7'b0000010,
		S_SETUP = 7'b0000100,
		S_DIV   = 7'b0001000,
		S_KSEL  = 7'b0010000,
		S_VAR   = 7'b0100000,
		S_FIN   = 7'b1000000
	} skf_state_t;

	skf_state_t state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q, cnt_nxt;

	always_comb begin
		state_nxt = state_q;
		cnt_nxt   = cnt_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep  = 1'b1;
				state_nxt = S_SETUP;
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				cnt_nxt   = '0;
				state_nxt = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_nxt      = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(GAIN_BITS - 1)) begin
					state_nxt = S_KSEL;
				end
			end
			S_KSEL: begin
				cmd.ksel  = 1'b1;
				cnt_nxt   = '0;
				state_nxt = S_VAR;
			end
			S_VAR: begin
				cmd.var_step = 1'b1;
				cnt_nxt      = cnt_q + CNT_W'(1);
				// one step per multiplier bit, GAIN_BITS+1 bits in all
				if (cnt_q == CNT_W'(GAIN_BITS)) begin
					state_nxt = S_FIN;
				end
			end
			S_FIN: begin
				// hold until the output register can take the word
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= cnt_nxt;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

// ===== hw/rtl/skf_datapath.sv =====
// Datapath of the scalar range filter: filter state, restoring gain
// divider, serial variance multiplier and the output register.
// Depends on skf_pkg for widths, the config word and command/status words.
module skf_datapath #(
	parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF,
	parameter int GAIN_BITS = skf_pkg::GAIN_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  skf_pkg::skf_cfg_t                      cfg,
	input  skf_pkg::skf_cmd_t                      cmd,
	output skf_pkg::skf_status_t                   status,
	input  logic [skf_pkg::SAMPLE_W-1:0]           sample,
	input  logic                                   restart,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [skf_pkg::EST_INT_W+FRAC_BITS-1:0] estimate,
	output logic [skf_pkg::ERR_INT_W+FRAC_BITS-1:0] error_variance,
	output logic [GAIN_BITS-1:0]                   gain
);
	import skf_pkg::*;

	localparam int EST_W  = EST_INT_W + FRAC_BITS;
	localparam int ERR_W  = ERR_INT_W + FRAC_BITS;
	localparam int DEN_W  = ERR_W + 1;
	localparam int MUL_W  = GAIN_BITS + EST_W;
	localparam int PROD_W = ERR_W + GAIN_BITS + 1;

	localparam logic [EST_W-1:0] EST_RST =
		EST_W'(RST_INITIAL_ESTIMATE) << FRAC_BITS;
	localparam logic [ERR_W-1:0] ERR_RST =
		ERR_W'(RST_INITIAL_ERROR) << FRAC_BITS;
	localparam logic [MUL_W:0]  MUL_HALF  = (MUL_W + 1)'(1) << (GAIN_BITS - 1);
	localparam logic [PROD_W:0] PROD_HALF = (PROD_W + 1)'(1) << (GAIN_BITS - 1);

	logic [SAMPLE_W-1:0]  z_q;
	logic [EST_W-1:0]     est_q;
	logic [ERR_W-1:0]     err_q;
	logic [ERR_W-1:0]     p1_q;
	logic [DEN_W-1:0]     den_q;
	logic [DEN_W-1:0]     rem_q;
	logic [GAIN_BITS-1:0] quo_q;
	logic [GAIN_BITS-1:0] k_q;
	logic [EST_W-1:0]     mag_q;
	logic                 neg_q;
	logic [GAIN_BITS:0]   mplier_q;
	logic [PROD_W-1:0]    acc_q;
	logic [MUL_W-1:0]     prod_q;
	logic                 out_valid_q;
	logic [EST_W-1:0]     est_out_q;
	logic [ERR_W-1:0]     err_out_q;
	logic [GAIN_BITS-1:0] gain_out_q;

	logic [DEN_W-1:0]     p1_sum;
	logic [ERR_W-1:0]     p1_nxt;
	logic [DEN_W-1:0]     den_nxt;
	logic [DEN_W:0]       rem_sh;
	logic [DEN_W:0]       rem_sub;
	logic                 rem_ge;
	logic [DEN_W-1:0]     rem_nxt;
	logic [GAIN_BITS-1:0] k_nxt;
	logic [EST_W-1:0]     zf;
	logic                 zf_ge;
	logic [EST_W-1:0]     mag_nxt;
	logic [GAIN_BITS:0]   mplier_nxt;
	logic [PROD_W-1:0]    acc_nxt;
	logic [MUL_W:0]       corr_sum;
	logic [EST_W-1:0]     corr;
	logic [EST_W-1:0]     est_nxt;
	logic [PROD_W:0]      pn_sum;
	logic [ERR_W-1:0]     pn;

	// predict: P1 = sat(P + Q)
	assign p1_sum  = {1'b0, err_q} + DEN_W'({cfg.q, {FRAC_BITS{1'b0}}});
	assign p1_nxt  = p1_sum[ERR_W] ? {ERR_W{1'b1}} : p1_sum[ERR_W-1:0];
	assign den_nxt = {1'b0, p1_q} + DEN_W'({cfg.r, {FRAC_BITS{1'b0}}});

	// restoring division, one quotient bit per step
	assign rem_sh  = {rem_q, 1'b0};
	assign rem_ge  = (rem_sh >= {1'b0, den_q});
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign rem_nxt = rem_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];

	// without sensor noise the gain is full scale, or zero if P1 is zero too
	always_comb begin
		if (cfg.r == '0) begin
			k_nxt = (p1_q == '0) ? '0 : {GAIN_BITS{1'b1}};
		end else begin
			k_nxt = quo_q;
		end
	end

	assign zf         = {z_q, {FRAC_BITS{1'b0}}};
	assign zf_ge      = (zf >= est_q);
	assign mag_nxt    = zf_ge ? (zf - est_q) : (est_q - zf);
	assign mplier_nxt = {1'b1, {GAIN_BITS{1'b0}}} - {1'b0, k_nxt};

	// MSB-first shift-add for (1 - K) * P1
	assign acc_nxt = {acc_q[PROD_W-2:0], 1'b0} + (mplier_q[GAIN_BITS] ? PROD_W'(p1_q) : '0);

	assign corr_sum = {1'b0, prod_q} + MUL_HALF;
	assign corr     = corr_sum[GAIN_BITS +: EST_W];
	assign est_nxt  = neg_q ? (est_q - corr) : (est_q + corr);
	assign pn_sum   = {1'b0, acc_q} + PROD_HALF;
	assign pn       = pn_sum[GAIN_BITS +: ERR_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q       <= EST_RST;
			err_q       <= ERR_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture && restart) begin
				est_q <= {cfg.init_est, {FRAC_BITS{1'b0}}};
				err_q <= ERR_W'({cfg.init_err, {FRAC_BITS{1'b0}}});
			end else if (cmd.finish) begin
				est_q <= est_nxt;
				err_q <= pn;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			z_q <= sample;
		end
		if (cmd.prep) begin
			p1_q <= p1_nxt;
		end
		if (cmd.setup) begin
			den_q <= den_nxt;
			rem_q <= {1'b0, p1_q};
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[GAIN_BITS-2:0], rem_ge};
		end
		if (cmd.ksel) begin
			k_q      <= k_nxt;
			mag_q    <= mag_nxt;
			neg_q    <= !zf_ge;
			mplier_q <= mplier_nxt;
			acc_q    <= '0;
		end
		if (cmd.var_step) begin
			acc_q    <= acc_nxt;
			mplier_q <= {mplier_q[GAIN_BITS-1:0], 1'b0};
			prod_q   <= k_q * mag_q;
		end
		if (cmd.finish) begin
			est_out_q  <= est_nxt;
			err_out_q  <= pn;
			gain_out_q <= k_q;
		end
	end

	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid       = out_valid_q;
	assign estimate        = est_out_q;
	assign error_variance  = err_out_q;
	assign gain            = gain_out_q;

`ifndef SYNTH
	a_finish_shows_word: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("finished word not shown on the output");
	a_variance_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (pn <= p1_q))
		else $error("updated variance exceeds predicted variance");
	a_correction_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (corr <= mag_q))
		else $error("estimate correction overshoots the sample");
	a_no_finish_while_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !cmd.finish)
		else $error("output overwritten while stalled");
`endif

endmodule

// ===== hw/rtl/scalar_kalman_filter.sv =====
// Scalar range filter: one-dimensional Kalman update per sample.
// Input channel (in_valid/in_stall): sample and restart, one word per update.
// Output channel (out_valid/out_stall): estimate (Q15.F), error_variance
// (Q24.F, saturating) and gain (Q0.G) of that update.
// Config port: cfg_we/cfg_index/cfg_data write process_noise (0),
// sensor_noise (1), initial_error (2), initial_estimate (3); other indexes
// are dropped. Write only while no update is in flight.
// Flow: a word is taken only while idle; in_stall stays high until that word's
// writeback, so a new word is not taken before the last one is through.
// Each update runs the restoring gain divider (GAIN_BITS steps) and the
// serial variance multiplier (GAIN_BITS+1 steps), which run one after other.
// A finished word waits in the output register; the next word is accepted
// meanwhile, and its writeback holds until out_stall drops.
// Reset: config registers take their defaults, the estimate and variance
// load 4000 and 5000 in integer units, and the output channel empties.
// restart reloads the estimate and variance from the config registers.
module scalar_kalman_filter #(
	parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF,
	parameter int GAIN_BITS = skf_pkg::GAIN_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [skf_pkg::CFG_IDX_W-1:0]            cfg_index,
	input  logic [skf_pkg::CFG_DATA_W-1:0]           cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic [skf_pkg::SAMPLE_W-1:0]             sample,
	input  logic                                    restart,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [skf_pkg::EST_INT_W+FRAC_BITS-1:0]  estimate,
	output logic [skf_pkg::ERR_INT_W+FRAC_BITS-1:0]  error_variance,
	output logic [GAIN_BITS-1:0]                    gain
);
	import skf_pkg::*;

	skf_cfg_t    cfg;
	skf_cmd_t    cmd;
	skf_status_t status;

	skf_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	skf_ctrl #(
		.GAIN_BITS (GAIN_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	skf_datapath #(
		.FRAC_BITS (FRAC_BITS),
		.GAIN_BITS (GAIN_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.status         (status),
		.sample         (sample),
		.restart        (restart),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.estimate       (estimate),
		.error_variance (error_variance),
		.gain           (gain)
	);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for scalar_kalman_filter: drives range samples with restarts,
// predicts each estimate, variance and gain in fixed point and compares every output word.
// Depends on skf_pkg and the filter RTL only.
module testbench;
	import skf_pkg::*;

	localparam int FRAC       = FRAC_BITS_DEF;
	localparam int GB         = GAIN_BITS_DEF;
	localparam int EST_W      = EST_INT_W + FRAC;
	localparam int ERR_W      = ERR_INT_W + FRAC;
	localparam logic [63:0] EST_MAX  = (64'd1 << EST_W) - 1;
	localparam logic [63:0] ERR_MAX  = (64'd1 << ERR_W) - 1;
	localparam logic [63:0] GAIN_ONE = 64'd1 << GB;
	localparam logic [63:0] GAIN_MAX = GAIN_ONE - 1;
	localparam int HOLD_CYCLES = 500;
	localparam int IDLE_LIMIT  = 4000;
	localparam int TAIL_CYCLES = 2 * GB + 40;

	typedef struct packed {
		logic [EST_W-1:0] est;
		logic [ERR_W-1:0] pvar;
		logic [GB-1:0]    k;
	} filter_word_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [SAMPLE_W-1:0] sample = '0;
	logic restart = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [EST_W-1:0] estimate;
	logic [ERR_W-1:0] error_variance;
	logic [GB-1:0] gain;

	// filter model: register copies and running state
	logic [63:0] q_noise, r_noise, init_err, init_est;
	logic [63:0] est_now, pvar_now;
	filter_word_t filter_results_due[$];

	int mismatches = 0;
	int n_checked = 0;
	int n_sent = 0;
	int n_restarts = 0;
	int n_cfg_writes = 0;
	int idle_cycles = 0;
	bit quiet = 0;
	bit hold_req = 0;

	scalar_kalman_filter #(.FRAC_BITS(FRAC), .GAIN_BITS(GB)) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample), .restart(restart),
		.out_valid(out_valid), .out_stall(out_stall),
		.estimate(estimate), .error_variance(error_variance), .gain(gain)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void reload_state();
		est_now = (init_est << FRAC) & EST_MAX;
		pvar_now = init_err << FRAC;
		if (pvar_now > ERR_MAX) pvar_now = ERR_MAX;
	endfunction

	function automatic void filter_reset();
		q_noise = RST_PROCESS_NOISE;
		r_noise = RST_SENSOR_NOISE;
		init_err = RST_INITIAL_ERROR;
		init_est = RST_INITIAL_ESTIMATE;
		reload_state();
	endfunction

	// One predict/update step on the model state; returns the word the block should emit.
	function automatic filter_word_t kalman_update(input logic [SAMPLE_W-1:0] z, input logic rs);
		logic [63:0] p1, den, k, zf, mag, corr, pn;
		filter_word_t w;
		if (rs) reload_state();
		p1 = pvar_now + (q_noise << FRAC);
		if (p1 > ERR_MAX) p1 = ERR_MAX;
		den = p1 + (r_noise << FRAC);
		if (den == 0) begin
			k = 0;
		end else begin
			k = (p1 << GB) / den;
			if (k > GAIN_MAX) k = GAIN_MAX;
		end
		zf = 64'(z) << FRAC;
		if (zf >= est_now) begin
			mag = zf - est_now;
			corr = (k * mag + (GAIN_ONE >> 1)) >> GB;
			est_now = est_now + corr;
			if (est_now > EST_MAX) est_now = EST_MAX;
		end else begin
			mag = est_now - zf;
			corr = (k * mag + (GAIN_ONE >> 1)) >> GB;
			est_now = (corr > est_now) ? 64'd0 : est_now - corr;
		end
		pn = ((GAIN_ONE - k) * p1 + (GAIN_ONE >> 1)) >> GB;
		if (pn > ERR_MAX) pn = ERR_MAX;
		pvar_now = pn;
		w.est = est_now[EST_W-1:0];
		w.pvar = pvar_now[ERR_W-1:0];
		w.k = k[GB-1:0];
		return w;
	endfunction

	// mostly short gaps, a few long ones; none while quiet
	function automatic int rand_gap();
		int roll;
		if (quiet) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_value(input int w);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return CFG_DATA_W'((64'd1 << w) - 1);
			2: return CFG_DATA_W'($urandom_range(1, 100));
			3: return CFG_DATA_W'($urandom());
			default: return CFG_DATA_W'($urandom() & ((64'd1 << w) - 1));
		endcase
	endfunction

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_PROCESS_NOISE:    q_noise = 64'(val[Q_W-1:0]);
			REG_SENSOR_NOISE:     r_noise = 64'(val[R_W-1:0]);
			REG_INITIAL_ERROR:    init_err = 64'(val[INIT_ERR_W-1:0]);
			REG_INITIAL_ESTIMATE: init_est = 64'(val[INIT_EST_W-1:0]);
			default: ;
		endcase
		n_cfg_writes++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] q, input logic [CFG_DATA_W-1:0] r,
			input logic [CFG_DATA_W-1:0] ie, input logic [CFG_DATA_W-1:0] ix);
		cfg_write(REG_PROCESS_NOISE, q);
		cfg_write(REG_SENSOR_NOISE, r);
		cfg_write(REG_INITIAL_ERROR, ie);
		cfg_write(REG_INITIAL_ESTIMATE, ix);
	endtask

	// Offer one word; hold it until accepted and queue its prediction.
	task automatic send_sample(input logic [SAMPLE_W-1:0] z, input logic rs);
		int gap;
		gap = rand_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= z;
		restart <= rs;
		do @(posedge clk); while (in_stall);
		filter_results_due.push_back(kalman_update(z, rs));
		n_sent++;
		if (rs) n_restarts++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (filter_results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_defaults();
		send_sample(SAMPLE_W'(RST_INITIAL_ESTIMATE), 1'b0);
		send_sample('0, 1'b0);
		send_sample('1, 1'b0);
		send_sample(15'd1234, 1'b1);
		wait_idle();
	endtask

	task automatic test_register_extremes();
		set_config(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
		send_sample('0, 1'b1);
		send_sample('0, 1'b0);
		send_sample('1, 1'b0);
		wait_idle();
		set_config('0, 20'd1, '0, '0);
		send_sample('1, 1'b1);
		send_sample('1, 1'b0);
		send_sample('0, 1'b0);
		wait_idle();
	endtask

	task automatic test_zero_noise();
		// zero sensor noise: gain pins at full scale
		set_config(20'd100, '0, 20'd3000, 20'd5000);
		send_sample(15'd5000, 1'b1);
		send_sample(15'd6000, 1'b0);
		wait_idle();
		// zero variance and zero noise: empty denominator, gain drops to zero
		set_config('0, '0, '0, 20'd7);
		send_sample(15'd100, 1'b1);
		send_sample(15'd200, 1'b0);
		wait_idle();
	endtask

	task automatic test_ignored_index();
		for (int i = REG_INITIAL_ESTIMATE + 1; i < (1 << CFG_IDX_W); i++)
			cfg_write(CFG_IDX_W'(i), CFG_DATA_W'($urandom()));
		send_sample(15'd300, 1'b1);
		send_sample(15'd20000, 1'b0);
		wait_idle();
		// upper data bits beyond each narrower register's width must drop
		set_config(20'hF0005, 20'hA0040, 20'd90000, 20'hF8123);
		send_sample(15'd4200, 1'b1);
		wait_idle();
	endtask

	task automatic run_track(input int len);
		int target, spread, z;
		target = $urandom_range(0, (1 << SAMPLE_W) - 1);
		spread = 1 << (2 * $urandom_range(0, 5));
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0) target = $urandom_range(0, (1 << SAMPLE_W) - 1);
			z = target + $urandom_range(0, 2 * spread) - spread;
			if (z < 0) z = 0;
			if (z > (1 << SAMPLE_W) - 1) z = (1 << SAMPLE_W) - 1;
			send_sample(SAMPLE_W'(z), i == 0);
		end
	endtask

	task automatic test_random_tracks(input int phases, input int per_phase);
		int start;
		for (int p = 0; p < phases; p++) begin
			set_config(pick_value(Q_W), pick_value(R_W), pick_value(INIT_ERR_W),
				pick_value(INIT_EST_W));
			start = n_sent;
			while (n_sent - start < per_phase) begin
				if ($urandom_range(0, 99) < 80) begin
					run_track($urandom_range(5, 30));
				end else begin
					repeat ($urandom_range(1, 5))
						send_sample(SAMPLE_W'($urandom()), $urandom_range(0, 3) == 0);
				end
			end
			wait_idle();
		end
	endtask

	task automatic test_backpressure();
		hold_req = 1;
		run_track(14);
		wait_idle();
	endtask

	task automatic test_no_idle();
		quiet = 1;
		run_track(20);
		run_track(20);
		wait_idle();
		quiet = 0;
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int n;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
			end else begin
				n = rand_gap();
				if (n == 0) begin
					out_stall <= 1'b0;
					@(posedge clk);
				end else begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		filter_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (filter_results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] unexpected word: est=%0h var=%0h gain=%0h",
						$realtime, estimate, error_variance, gain);
			end else begin
				want = filter_results_due.pop_front();
				n_checked++;
				if (want.est !== estimate || want.pvar !== error_variance || want.k !== gain) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] word %0d: est %0h/%0h var %0h/%0h gain %0h/%0h (exp/got)",
							$realtime, n_checked, want.est, estimate, want.pvar,
							error_variance, want.k, gain);
				end
			end
		end
	end

	// watchdog: too long with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired after %0d idle cycles", idle_cycles);
			$display("** scalar_kalman_filter: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		filter_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_register_extremes();
		test_zero_noise();
		test_ignored_index();
		test_random_tracks(8, 52);
		test_backpressure();
		test_no_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d samples (%0d restarts) over %0d register writes; %0d words checked.",
			n_sent, n_restarts, n_cfg_writes, n_checked);
		$display("Included zero noise, empty denominator, long output hold-off, no-gap streams.");
		if (mismatches == 0 && filter_results_due.size() == 0) begin
			$display("** scalar_kalman_filter: PASSED **");
		end else begin
			$display("%0d mismatches, %0d words missing", mismatches, filter_results_due.size());
			$display("** scalar_kalman_filter: FAILED **");
		end
		$finish;
	end

endmodule
